@@ design/scanline_point_binner_unit_assert.svh @@
// assertion macros used by the scanline point binner rtl
// needs a clock named clk and a synchronous reset named rst in scope
`ifndef SCANLINE_POINT_BINNER_UNIT_ASSERT_SVH
`define SCANLINE_POINT_BINNER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SPB_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked outside reset
`define SPB_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ design/spb_pkg.sv @@
// types, codes and fixed widths of the scanline point binner
// no dependencies
package spb_pkg;

  // opcodes and result kinds
  localparam logic OP_BIN      = 1'b0;
  localparam logic OP_FLUSH    = 1'b1;
  localparam logic KIND_POINT  = 1'b0;
  localparam logic KIND_COUNT  = 1'b1;

  // register indexes
  localparam logic [1:0] REG_CLIP_SCALE   = 2'd0;
  localparam logic [1:0] REG_VIEW_DIST    = 2'd1;
  localparam logic [1:0] REG_ACTIVE_LINES = 2'd2;
  localparam logic [1:0] REG_DEPTH_OFFSET = 2'd3;

  // register reset values
  localparam logic [23:0] CLIP_SCALE_RST   = 24'd1310720;
  localparam logic [23:0] VIEW_DIST_RST    = 24'd786432;
  localparam logic [9:0]  ACTIVE_LINES_RST = 10'd144;

  // fixed-point constants
  localparam int ONE_Q16  = 65536;
  localparam int YH_LIMIT = 4 * ONE_Q16;

  // divider widths: v * |py_c| and |v - pz_c|
  localparam int NUM_W = 56;
  localparam int DEN_W = 33;

  typedef struct packed {
    logic               opcode;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic [7:0]         point_luma;
    logic [8:0]         flush_line;
  } spb_in_t;

  typedef struct packed {
    logic               result_kind;
    logic [8:0]         line_index;
    logic [3:0]         slot_index;
    logic signed [23:0] out_x;
    logic signed [23:0] out_z;
    logic [7:0]         out_luma;
    logic [4:0]         line_count;
  } spb_out_t;

  // count store port controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } spb_mem_ctl_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ZSAT,
    ST_MULY,
    ST_MULZ,
    ST_DEN,
    ST_MULN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_YH,
    ST_LINE,
    ST_LREAD,
    ST_CHECK,
    ST_FCHECK
  } spb_state_t;

endpackage

@@ design/spb_divider.sv @@
// iterative restoring divider, one quotient bit per cycle
// uses spb_pkg for the operand widths
module spb_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [spb_pkg::NUM_W-1:0]  num,
  input  logic [spb_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [spb_pkg::NUM_W-1:0]  quot,
  output logic                       rem_nz
);
  import spb_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             take;

  // trial subtract of the shifted remainder
  assign trial = {rem, num_sh[NUM_W-1]};
  assign take  = (trial >= {1'b0, den});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(NUM_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient bits shift in behind the numerator
  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      rem    <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[NUM_W-2:0], take};
      rem    <= take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    end
  end

  assign quot   = num_sh;
  assign rem_nz = |rem;

endmodule

@@ design/spb_line_store.sv @@
// per-line fill counts in one synchronous memory, cleared by a sweep after reset
// uses spb_pkg for the port control struct
module spb_line_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int CW    = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  spb_pkg::spb_mem_ctl_t ctl,
  input  logic [AW-1:0]         rd_addr,
  input  logic [AW-1:0]         wr_addr,
  input  logic [CW-1:0]         wr_data,
  output logic [CW-1:0]         rd_data,
  output logic                  ready
);
  import spb_pkg::*;

  logic [CW-1:0] mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic          clearing;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (32'(clr_addr) == DEPTH - 1) begin
        clearing <= 1'b0;
      end
    end
  end

  // write port
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign ready = !clearing;

endmodule

@@ design/scanline_point_binner_unit.sv @@
// top level of the scanline point binner: registers, sequencer, projection datapath
// uses spb_pkg, spb_divider, spb_line_store and the assertion macro header
//
//  channel   direction  handshake                 payload
//  in        input      in_valid / in_stall       in_data   (spb_in_t)
//  out       output     out_valid / out_stall     out_data  (spb_out_t)
//  config    input      psel/penable/pwrite       paddr, pwdata, prdata
//
// a point passes the clip multiplies, the divider and a count store read
// a flush: one count store read, then report and clear once the output is free
// after reset all MAX_LINES count store entries are swept, in_stall stays high
// items are taken one at a time; the next is accepted while a result waits in
// the output register, which holds its transaction while out_stall is high
module scanline_point_binner_unit #(
  parameter int MAX_LINES      = 512,
  parameter int SLOTS_PER_LINE = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  spb_pkg::spb_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output spb_pkg::spb_out_t out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import spb_pkg::*;

  localparam int LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CW = $clog2(SLOTS_PER_LINE + 1);

  // configuration registers
  logic [23:0]        clip_scale;
  logic [23:0]        view_dist;
  logic [9:0]         active_lines;
  logic signed [23:0] depth_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_scale   <= CLIP_SCALE_RST;
      view_dist    <= VIEW_DIST_RST;
      active_lines <= ACTIVE_LINES_RST;
      depth_offset <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_CLIP_SCALE:   clip_scale   <= pwdata[23:0];
        REG_VIEW_DIST:    view_dist    <= pwdata[23:0];
        REG_ACTIVE_LINES: active_lines <= pwdata[9:0];
        REG_DEPTH_OFFSET: depth_offset <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_CLIP_SCALE:   prdata = {8'd0, clip_scale};
      REG_VIEW_DIST:    prdata = {8'd0, view_dist};
      REG_ACTIVE_LINES: prdata = {22'd0, active_lines};
      REG_DEPTH_OFFSET: prdata = {8'd0, depth_offset};
      default:          prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // lines in use, capped at capacity
  logic [9:0] lines;
  assign lines = (32'(active_lines) > MAX_LINES) ? 10'(MAX_LINES) : active_lines;

  // state and item registers
  spb_state_t          state, state_next;
  logic signed [23:0]  item_x, item_y, item_z;
  logic [7:0]          item_luma;
  logic [8:0]          fl_line;
  logic                fl_ok;
  logic signed [23:0]  z_sat;
  logic signed [31:0]  py_c, pz_c;
  logic [31:0]         py_mag;
  logic [DEN_W-1:0]    den_mag;
  logic                qneg;
  logic [NUM_W-1:0]    num_mag;
  logic signed [19:0]  yh;
  logic signed [14:0]  line;
  logic                line_ok;

  // datapath wires
  logic signed [24:0]  z_sum;
  logic signed [23:0]  mul_a;
  logic signed [48:0]  mul_p;
  logic signed [32:0]  den_s;
  logic [NUM_W:0]      mag_pre;
  logic [19:0]         mag_clamp;
  logic signed [20:0]  lin_diff;
  logic signed [31:0]  lin_prod;

  // count store and divider wiring
  spb_mem_ctl_t        mem_ctl;
  logic [LW-1:0]       rd_addr, wr_addr;
  logic [CW-1:0]       wr_data, rd_data;
  logic                store_ready;
  logic                div_start, div_done, div_rem_nz;
  logic [NUM_W-1:0]    div_quot;

  // output register control
  logic                out_free, out_load;
  spb_out_t            out_next;
  logic                in_accept;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // saturating depth offset
  assign z_sum = 25'(item_z) + 25'(depth_offset);
  // shared clip scaling multiplier, y then z
  assign mul_a = (state == ST_MULY) ? item_y : z_sat;
  assign mul_p = 49'(mul_a) * $signed({1'b0, clip_scale});
  assign den_s = $signed({9'd0, view_dist}) - 33'(pz_c);
  // floor of a negative quotient rounds the magnitude up
  assign mag_pre   = (NUM_W + 1)'(div_quot) + (NUM_W + 1)'(qneg && div_rem_nz);
  assign mag_clamp = (mag_pre > (NUM_W + 1)'(YH_LIMIT)) ? 20'(YH_LIMIT) : mag_pre[19:0];
  // scanline from yh: floor(L * (1 - yh) / 2)
  assign lin_diff = 21'(ONE_Q16) - 21'(yh);
  assign lin_prod = 32'($signed({1'b0, lines})) * 32'(lin_diff);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_ctl    = '0;
    rd_addr    = LW'(line);
    wr_addr    = LW'(line);
    wr_data    = rd_data + CW'(1);
    div_start  = 1'b0;
    out_load   = 1'b0;
    out_next   = '0;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        if (store_ready) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.opcode == OP_FLUSH) begin
            mem_ctl.rd_en = (32'(in_data.flush_line) < MAX_LINES);
            rd_addr       = LW'(in_data.flush_line);
            state_next    = ST_FCHECK;
          end else begin
            state_next = ST_ZSAT;
          end
        end
      end
      ST_ZSAT:      state_next = ST_MULY;
      ST_MULY:      state_next = ST_MULZ;
      ST_MULZ:      state_next = ST_DEN;
      ST_DEN:       state_next = (den_s == '0) ? ST_IDLE : ST_MULN;
      ST_MULN:      state_next = ST_DIV_START;
      ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) state_next = ST_YH;
      end
      ST_YH:        state_next = ST_LINE;
      ST_LINE:      state_next = ST_LREAD;
      ST_LREAD: begin
        mem_ctl.rd_en = line_ok;
        state_next    = line_ok ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        if (32'(rd_data) >= SLOTS_PER_LINE) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          mem_ctl.wr_en        = 1'b1;
          out_load             = 1'b1;
          out_next.result_kind = KIND_POINT;
          out_next.line_index  = line[8:0];
          out_next.slot_index  = 4'(rd_data);
          out_next.out_x       = item_x;
          out_next.out_z       = z_sat;
          out_next.out_luma    = item_luma;
          state_next           = ST_IDLE;
        end
      end
      ST_FCHECK: begin
        wr_addr = LW'(fl_line);
        wr_data = '0;
        if (out_free) begin
          mem_ctl.wr_en        = fl_ok;
          out_load             = 1'b1;
          out_next.result_kind = KIND_COUNT;
          out_next.line_index  = fl_line;
          out_next.line_count  = fl_ok ? 5'(rd_data) : 5'd0;
          state_next           = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_x    <= in_data.point_x;
      item_y    <= in_data.point_y;
      item_z    <= in_data.point_z;
      item_luma <= in_data.point_luma;
      fl_line   <= in_data.flush_line;
      fl_ok     <= (32'(in_data.flush_line) < MAX_LINES);
    end
    if (state == ST_ZSAT) begin
      if (z_sum > 25'sd8388607)       z_sat <= 24'sh7FFFFF;
      else if (z_sum < -25'sd8388608) z_sat <= 24'sh800000;
      else                            z_sat <= z_sum[23:0];
    end
    if (state == ST_MULY) py_c <= mul_p[47:16];
    if (state == ST_MULZ) pz_c <= mul_p[47:16];
    if (state == ST_DEN) begin
      qneg    <= py_c[31] ^ den_s[32];
      py_mag  <= py_c[31] ? 32'(-py_c) : 32'(py_c);
      den_mag <= den_s[32] ? DEN_W'(-den_s) : DEN_W'(den_s);
    end
    if (state == ST_MULN) num_mag <= NUM_W'(view_dist) * NUM_W'(py_mag);
    if (state == ST_YH) yh <= qneg ? -$signed(mag_clamp) : $signed(mag_clamp);
    if (state == ST_LINE) begin
      line    <= lin_prod[31:17];
      line_ok <= !lin_prod[31] && (lin_prod[31:17] < $signed({5'd0, lines}));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data <= out_next;
  end

  spb_divider u_divider (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (num_mag),
    .den    (den_mag),
    .done   (div_done),
    .quot   (div_quot),
    .rem_nz (div_rem_nz)
  );

  spb_line_store #(
    .DEPTH (MAX_LINES),
    .AW    (LW),
    .CW    (CW)
  ) u_line_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .ready   (store_ready)
  );

`include "scanline_point_binner_unit_assert.svh"

  `SPB_ASSERT_IMP(a_wr_in_check, mem_ctl.wr_en, (state == ST_CHECK || state == ST_FCHECK), "count write outside check")
  `SPB_ASSERT_NXT(a_one_at_a_time, in_accept, in_stall, "item accepted while busy")
  `SPB_ASSERT_IMP(a_no_load_over_held, out_load, !(out_valid && out_stall), "held result overwritten")
  `SPB_ASSERT_IMP(a_div_idle_start, div_start, (state == ST_DIV_START && !div_done), "divider started out of order")

endmodule

@@ test/scanline_point_binner_unit_tb.sv @@
// testbench for scanline_point_binner_unit: directed, random and back-pressure traffic
// checked against a built-in line binning predictor; depends on spb_pkg and the rtl
`timescale 1ns / 100ps

module scanline_point_binner_unit_tb;
  import spb_pkg::*;

  localparam int LINE_CAP     = 512;
  localparam int SLOT_CAP     = 16;
  localparam int DRAIN_CYCLES = 100;
  localparam int LIMIT_CYCLES = 1000000;
  localparam longint Q16      = 65536;
  localparam int IN_W         = $bits(spb_in_t);

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  spb_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  spb_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of configuration and line counts
  logic [23:0] clip_reg;
  logic [23:0] view_reg;
  logic [9:0]  lines_reg;
  logic [23:0] offset_reg;
  int          fill_count [LINE_CAP];

  spb_out_t    pending_writes [$];
  int          fail_count;
  int          send_idle;
  int          recv_idle;
  bit          hold_off;
  longint      cycle_count = 0;

  scanline_point_binner_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stall, random or held off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle);
    end
  end

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // line binning predictor: returns 1 when the item yields a transaction
  function automatic bit bin_point(spb_in_t it, output spb_out_t res);
    longint z, py_c, pz_c, v, den, num, yh, nlines, line;
    int     cnt;
    res = '0;
    if (it.opcode == OP_FLUSH) begin
      res.result_kind = KIND_COUNT;
      res.line_index  = it.flush_line;
      res.line_count  = 5'(fill_count[it.flush_line]);
      fill_count[it.flush_line] = 0;
      return 1;
    end
    z    = sat24(longint'(it.point_z) + longint'($signed(offset_reg)));
    py_c = floor_div(longint'(it.point_y) * longint'(clip_reg), Q16);
    pz_c = floor_div(z * longint'(clip_reg), Q16);
    v    = longint'(view_reg);
    den  = v - pz_c;
    if (den == 0) return 0;
    num = v * py_c;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    yh = floor_div(num, den);
    if (yh > 4 * Q16) yh = 4 * Q16;
    if (yh < -4 * Q16) yh = -4 * Q16;
    nlines = (lines_reg > LINE_CAP) ? LINE_CAP : longint'(lines_reg);
    line = floor_div(nlines * (Q16 - yh), 2 * Q16);
    if (line < 0 || line >= nlines) return 0;
    cnt = fill_count[line];
    if (cnt >= SLOT_CAP) return 0;
    fill_count[line] = cnt + 1;
    res.result_kind = KIND_POINT;
    res.line_index  = line[8:0];
    res.slot_index  = cnt[3:0];
    res.out_x       = it.point_x;
    res.out_z       = z[23:0];
    res.out_luma    = it.point_luma;
    return 1;
  endfunction

  function automatic void check_field(string fname, longint want, longint got);
    if (want != got) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, fname, want, got);
      fail_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    spb_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_writes.size() == 0) begin
        $display("%0t unexpected transaction expected none actual %h", $time, out_data);
        fail_count++;
      end else begin
        want = pending_writes.pop_front();
        check_field("result_kind", want.result_kind, out_data.result_kind);
        check_field("line_index", want.line_index, out_data.line_index);
        check_field("slot_index", want.slot_index, out_data.slot_index);
        check_field("out_x", want.out_x, out_data.out_x);
        check_field("out_z", want.out_z, out_data.out_z);
        check_field("out_luma", want.out_luma, out_data.out_luma);
        check_field("line_count", want.line_count, out_data.line_count);
      end
    end
  end

  // one input transaction; entered and left at a falling edge
  task automatic send_item(spb_in_t it);
    spb_out_t res;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (bin_point(it, res)) pending_writes = {pending_writes, res};
    @(negedge clk);
  endtask

  // register write plus readback; entered and left at a falling edge
  task automatic reg_write(logic [1:0] idx, logic [23:0] value);
    logic [31:0] mask;
    mask = (idx == REG_ACTIVE_LINES) ? 32'h3ff : 32'hffffff;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {8'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CLIP_SCALE:   clip_reg   = value;
      REG_VIEW_DIST:    view_reg   = value;
      REG_ACTIVE_LINES: lines_reg  = value[9:0];
      default:          offset_reg = value;
    endcase
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("readback", {8'd0, value} & mask, prdata & mask);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // wait until the block is idle before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(logic [23:0] c, logic [23:0] v, logic [9:0] l, logic [23:0] o);
    settle();
    reg_write(REG_CLIP_SCALE, c);
    reg_write(REG_VIEW_DIST, v);
    reg_write(REG_ACTIVE_LINES, {14'd0, l});
    reg_write(REG_DEPTH_OFFSET, o);
  endtask

  function automatic spb_in_t make_point(int x, int y, int z, int luma);
    spb_in_t it;
    it = '0;
    it.opcode     = OP_BIN;
    it.point_x    = 24'(x);
    it.point_y    = 24'(y);
    it.point_z    = 24'(z);
    it.point_luma = 8'(luma);
    it.flush_line = 9'($urandom);
    return it;
  endfunction

  function automatic spb_in_t make_flush(int line);
    spb_in_t it;
    it = IN_W'({$urandom, $urandom, $urandom});
    it.opcode     = OP_FLUSH;
    it.flush_line = 9'(line);
    return it;
  endfunction

  // point aimed at the visible lines under the current settings
  function automatic spb_in_t aimed_point();
    longint c, yspan, zspan, zr, y;
    c     = (clip_reg < 256) ? 256 : longint'(clip_reg);
    yspan = (Q16 * Q16) / c;
    if (yspan > 8388607) yspan = 8388607;
    zspan = longint'(view_reg) * (Q16 / 2) / c;
    if (zspan > 8388607) zspan = 8388607;
    y  = longint'($urandom_range(0, 32'(2 * yspan))) - yspan;
    zr = longint'($urandom_range(0, 32'(2 * zspan))) - zspan;
    zr = sat24(zr - longint'($signed(offset_reg)));
    return make_point(int'($urandom), int'(y), int'(zr), int'($urandom_range(0, 255)));
  endfunction

  function automatic spb_in_t random_item();
    int     pick;
    int     nl;
    spb_in_t it;
    pick = $urandom_range(0, 99);
    nl   = (lines_reg == 0) ? 1 : ((lines_reg > LINE_CAP) ? LINE_CAP : lines_reg);
    if (pick < 12) begin
      it = make_flush((pick < 10) ? $urandom_range(0, nl - 1) : $urandom_range(0, 511));
    end else if (pick < 85) begin
      it = aimed_point();
    end else begin
      it = IN_W'({$urandom, $urandom, $urandom});
    end
    return it;
  endfunction

  task automatic random_run(int count);
    repeat (count) send_item(random_item());
  endtask

  task automatic test_reset_defaults();
    send_item(make_point(100, 0, 0, 7));
    send_item(make_point(-5, 0, 0, 8));
    send_item(make_flush(72));
    send_item(make_flush(72));
  endtask

  task automatic test_directed_extremes();
    send_item(make_point(8388607, 8388607, 8388607, 255));
    send_item(make_point(-8388608, -8388608, -8388608, 0));
    send_item(make_point(0, 3000, -3000, 255));
    send_item(make_point(0, -3000, 3000, 0));
    // fill one line beyond its slots to see the full-line drop
    repeat (SLOT_CAP + 2) send_item(make_point($urandom, 0, 0, $urandom_range(0, 255)));
    send_item(make_flush(0));
    send_item(make_flush(511));
    send_item(make_flush(72));
  endtask

  task automatic test_zero_denominator();
    // zero view distance with zero depth: denominator vanishes
    set_config(CLIP_SCALE_RST, 24'd0, ACTIVE_LINES_RST, 24'd0);
    send_item(make_point(1, 500, 0, 3));
    send_item(make_point(1, 500, 40, 3));
    send_item(make_point(1, 500, -40, 3));
    // saturation of z plus offset
    set_config(CLIP_SCALE_RST, VIEW_DIST_RST, ACTIVE_LINES_RST, 24'h7fffff);
    send_item(make_point(2, 0, 8388607, 9));
    set_config(CLIP_SCALE_RST, VIEW_DIST_RST, ACTIVE_LINES_RST, 24'h800000);
    send_item(make_point(2, 0, -8388608, 9));
  endtask

  task automatic test_config_extremes();
    set_config(24'd0, 24'hffffff, 10'd1, 24'd0);
    repeat (6) send_item(aimed_point());
    set_config(24'hffffff, 24'hffffff, 10'd512, 24'h800000);
    repeat (6) send_item(aimed_point());
    set_config(CLIP_SCALE_RST, VIEW_DIST_RST, 10'd0, 24'd0);
    repeat (4) send_item(aimed_point());
    set_config(CLIP_SCALE_RST, VIEW_DIST_RST, 10'h3ff, 24'd1000);
    repeat (6) send_item(aimed_point());
    send_item(make_flush(0));
  endtask

  task automatic test_random_traffic(int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (4) begin
      set_config(24'($urandom_range(16384, 3000000)), 24'($urandom_range(65536, 2000000)),
                 10'($urandom_range(1, 512)), 24'($urandom_range(0, 65535) - 32768));
      random_run(120);
    end
    set_config(CLIP_SCALE_RST, VIEW_DIST_RST, 10'($urandom_range(1, 40)), 24'd0);
    random_run(120);
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    set_config(CLIP_SCALE_RST, VIEW_DIST_RST, ACTIVE_LINES_RST, 24'd0);
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    repeat (40) send_item(make_flush($urandom_range(0, 143)));
    random_run(40);
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    fail_count  = 0;
    send_idle   = 0;
    recv_idle   = 0;
    hold_off    = 1'b0;
    clip_reg    = CLIP_SCALE_RST;
    view_reg    = VIEW_DIST_RST;
    lines_reg   = ACTIVE_LINES_RST;
    offset_reg  = '0;
    foreach (fill_count[i]) fill_count[i] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_directed_extremes();
    test_zero_denominator();
    test_config_extremes();
    test_random_traffic(11, 77);
    test_random_traffic(77, 11);
    test_random_traffic(0, 0);
    test_backpressure();

    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/spb_pkg.sv
design/spb_divider.sv
design/spb_line_store.sv
design/scanline_point_binner_unit.sv
test/scanline_point_binner_unit_tb.sv
